[rtl/mandelbrot_pixel_iterator_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the pixel iterator
// Concurrent checks on clk with rst_n low as disable; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_PIXEL_ITERATOR_TOP_ASSERT_SVH
`define MANDELBROT_PIXEL_ITERATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define MPI_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("mpi assertion failed");

`define MPI_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mpi implication failed");

`else

`define MPI_ASSERT_ALWAYS(lbl, expr)
`define MPI_ASSERT_IMPLY(lbl, ante, cons)

`endif

`endif

[rtl/mpi_pkg.sv]
// ----------------------------------------------------------------------------
// mpi_pkg
// Shared constants, payload types and helpers of the pixel iterator.
// ----------------------------------------------------------------------------
`default_nettype none

package mpi_pkg;

  localparam int MAX_ITER  = 16;
  localparam int FRAC_BITS = 10;
  localparam int COORD_W   = 16;
  localparam int POS_W     = 8;
  localparam int CNT_W     = $clog2(MAX_ITER + 1);
  localparam int COLOR_W   = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [COORD_W-1:0] LIMIT    = COORD_W'(2 << FRAC_BITS);
  localparam logic signed [COORD_W-1:0] MOST_NEG = {1'b1, {(COORD_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] CFG_X_LEFT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_TOP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_STEP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP = 2'd3;

  localparam logic [COORD_W-1:0] X_LEFT_RST = 16'hF800;
  localparam logic [COORD_W-1:0] Y_TOP_RST  = 16'hF800;
  localparam logic [COORD_W-1:0] X_STEP_RST = 16'd25;
  localparam logic [COORD_W-1:0] Y_STEP_RST = 16'd21;

  localparam logic [COLOR_W-1:0] PALETTE [0:15] = '{
    4'd0, 4'd11, 4'd12, 4'd15, 4'd1, 4'd2, 4'd9, 4'd4,
    4'd8, 4'd10, 4'd7, 4'd6, 4'd14, 4'd3, 4'd5, 4'd13
  };

  typedef struct packed {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]   pixel_col;
    logic [POS_W-1:0]   pixel_row;
    logic [CNT_W-1:0]   iterations;
    logic [COLOR_W-1:0] color;
  } out_item_t;

  typedef struct packed {
    logic                      vld;
    logic [POS_W-1:0]          col;
    logic [POS_W-1:0]          row;
    logic signed [COORD_W-1:0] c_re;
    logic signed [COORD_W-1:0] c_im;
    logic signed [COORD_W-1:0] re;
    logic signed [COORD_W-1:0] im;
    logic [CNT_W-1:0]          cnt;
  } iter_t;

  // 16-bit abs below 2.0; the most negative value keeps its sign and stays in
  function automatic logic in_range(input logic signed [COORD_W-1:0] v);
    return ((v > -LIMIT) && (v < LIMIT)) || (v == MOST_NEG);
  endfunction

endpackage

`default_nettype wire

[rtl/mpi_setup.sv]
// ----------------------------------------------------------------------------
// mpi_setup
// Forms c = (x_left + (col+1)*x_step, y_top + (row-2)*y_step) in two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module mpi_setup import mpi_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               xfer,
  input  wire in_item_t           in_item,
  input  wire logic [COORD_W-1:0] x_left,
  input  wire logic [COORD_W-1:0] y_top,
  input  wire logic [COORD_W-1:0] x_step,
  input  wire logic [COORD_W-1:0] y_step,
  output iter_t                   s_out
);

  logic [POS_W:0]         col_p1;
  logic [COORD_W-1:0]     row_m2;
  logic [POS_W+COORD_W:0] px_full;
  logic [2*COORD_W-1:0]   py_full;

  logic                   vld_r;
  logic [POS_W-1:0]       col_r;
  logic [POS_W-1:0]       row_r;
  logic [COORD_W-1:0]     px_r;
  logic [COORD_W-1:0]     py_r;
  iter_t                  s_r;
  iter_t                  s_nxt;

  assign col_p1  = {1'b0, in_item.col} + (POS_W+1)'(1);
  assign row_m2  = {{(COORD_W-POS_W){1'b0}}, in_item.row} - COORD_W'(2);
  assign px_full = col_p1 * x_step;
  assign py_full = row_m2 * y_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col_r <= in_item.col;
      row_r <= in_item.row;
      px_r  <= px_full[COORD_W-1:0];
      py_r  <= py_full[COORD_W-1:0];
    end
  end

  always_comb begin
    s_nxt      = '0;
    s_nxt.vld  = vld_r;
    s_nxt.col  = col_r;
    s_nxt.row  = row_r;
    s_nxt.c_re = x_left + px_r;
    s_nxt.c_im = y_top + py_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.vld <= 1'b0;
    end else if (en) begin
      s_r.vld <= s_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r.col  <= s_nxt.col;
      s_r.row  <= s_nxt.row;
      s_r.c_re <= s_nxt.c_re;
      s_r.c_im <= s_nxt.c_im;
      s_r.re   <= s_nxt.re;
      s_r.im   <= s_nxt.im;
      s_r.cnt  <= s_nxt.cnt;
    end
  end

  assign s_out = s_r;

endmodule

`default_nettype wire

[rtl/mpi_iter.sv]
// ----------------------------------------------------------------------------
// mpi_iter
// One escape-time iteration: products and escape test, then the sums.
// ----------------------------------------------------------------------------
`default_nettype none

module mpi_iter import mpi_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire iter_t s_in,
  output iter_t      s_out
);

  logic signed [2*COORD_W-1:0] rr;
  logic signed [2*COORD_W-1:0] ii;
  logic signed [2*COORD_W-1:0] ri;
  logic                        act;

  iter_t                       p_r;
  logic                        act_r;
  logic signed [COORD_W-1:0]   rr_r;
  logic signed [COORD_W-1:0]   ii_r;
  logic signed [COORD_W-1:0]   ri_r;

  iter_t                       s_r;
  iter_t                       s_nxt;

  assign rr  = s_in.re * s_in.re;
  assign ii  = s_in.im * s_in.im;
  assign ri  = s_in.re * s_in.im;
  assign act = (s_in.cnt < CNT_W'(MAX_ITER)) && in_range(s_in.re) && in_range(s_in.im);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r.vld <= 1'b0;
    end else if (en) begin
      p_r.vld <= s_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r.col  <= s_in.col;
      p_r.row  <= s_in.row;
      p_r.c_re <= s_in.c_re;
      p_r.c_im <= s_in.c_im;
      p_r.re   <= s_in.re;
      p_r.im   <= s_in.im;
      p_r.cnt  <= s_in.cnt;
      act_r    <= act;
      rr_r     <= rr[FRAC_BITS+COORD_W-1:FRAC_BITS];
      ii_r     <= ii[FRAC_BITS+COORD_W-1:FRAC_BITS];
      ri_r     <= ri[FRAC_BITS+COORD_W-2:FRAC_BITS-1];
    end
  end

  always_comb begin
    s_nxt = p_r;
    if (act_r) begin
      s_nxt.re  = rr_r - ii_r + p_r.c_re;
      s_nxt.im  = ri_r + p_r.c_im;
      s_nxt.cnt = p_r.cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.vld <= 1'b0;
    end else if (en) begin
      s_r.vld <= s_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r.col  <= s_nxt.col;
      s_r.row  <= s_nxt.row;
      s_r.c_re <= s_nxt.c_re;
      s_r.c_im <= s_nxt.c_im;
      s_r.re   <= s_nxt.re;
      s_r.im   <= s_nxt.im;
      s_r.cnt  <= s_nxt.cnt;
    end
  end

  assign s_out = s_r;

endmodule

`default_nettype wire

[rtl/mpi_out.sv]
// ----------------------------------------------------------------------------
// mpi_out
// Palette lookup and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mpi_out import mpi_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire iter_t s_in,
  output logic       out_valid,
  output out_item_t  out_data
);

  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t out_data_nxt;

  always_comb begin
    out_data_nxt.pixel_col  = s_in.col;
    out_data_nxt.pixel_row  = s_in.row;
    out_data_nxt.iterations = s_in.cnt;
    out_data_nxt.color      = (s_in.cnt == CNT_W'(MAX_ITER)) ? '0 : PALETTE[s_in.cnt[3:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[rtl/mandelbrot_pixel_iterator_top.sv]
// ----------------------------------------------------------------------------
// mandelbrot_pixel_iterator_top
// Fixed-point Q5.10 escape-time iterator, one pipeline unit per iteration.
// Pipeline: 2 setup stages, 2 stages per iteration for 16 iterations and
//   1 output register lie between input transfer and out_valid.
// Throughput: one pixel per cycle; the whole pipeline stalls while a result
//   waits on out_ready.
// Reset: synchronous, clears all valid bits and loads the default view.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mandelbrot_pixel_iterator_top_assert.svh"

module mandelbrot_pixel_iterator_top import mpi_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [COORD_W-1:0]   cfg_wdata
);

  logic               en;
  logic [COORD_W-1:0] x_left_r;
  logic [COORD_W-1:0] y_top_r;
  logic [COORD_W-1:0] x_step_r;
  logic [COORD_W-1:0] y_step_r;
  iter_t              chain [0:MAX_ITER];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_left_r <= X_LEFT_RST;
      y_top_r  <= Y_TOP_RST;
      x_step_r <= X_STEP_RST;
      y_step_r <= Y_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_X_LEFT: x_left_r <= cfg_wdata;
        CFG_Y_TOP:  y_top_r  <= cfg_wdata;
        CFG_X_STEP: x_step_r <= cfg_wdata;
        CFG_Y_STEP: y_step_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mpi_setup u_setup (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .xfer    (in_valid && in_ready),
    .in_item (in_data),
    .x_left  (x_left_r),
    .y_top   (y_top_r),
    .x_step  (x_step_r),
    .y_step  (y_step_r),
    .s_out   (chain[0])
  );

  for (genvar k = 0; k < MAX_ITER; k++) begin : g_iter
    mpi_iter u_iter (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .s_in  (chain[k]),
      .s_out (chain[k+1])
    );
  end

  mpi_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .s_in      (chain[MAX_ITER]),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // z starts at 0, so every pixel runs at least one iteration
  `MPI_ASSERT_IMPLY(a_iter_nonzero, out_valid, out_data.iterations != '0)
  `MPI_ASSERT_IMPLY(a_iter_bound, out_valid, out_data.iterations <= CNT_W'(MAX_ITER))
  `MPI_ASSERT_IMPLY(a_in_set_black, out_valid && (out_data.iterations == CNT_W'(MAX_ITER)),
                    out_data.color == '0)

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel iterator testbench
// Sends pixel positions over valid/ready, predicts the escape count and
// palette color of every input transfer, and checks results in order across
// several views (extremes included) and idle/stall patterns.
// ----------------------------------------------------------------------------
module testbench import mpi_pkg::*;;

  localparam int ESCAPE        = 2 << FRAC_BITS;
  localparam int RANDOM_PIXELS = 200;
  localparam int HOLD_CYCLES   = 400;
  localparam int MAX_GAP       = 40;

  class pixel_scoreboard;
    logic [COORD_W-1:0] x_left, y_top, x_step, y_step;
    logic [COLOR_W-1:0] hue [16];
    out_item_t          expected_px[$];
    int                 mismatches;

    function new();
      x_left     = X_LEFT_RST;
      y_top      = Y_TOP_RST;
      x_step     = X_STEP_RST;
      y_step     = Y_STEP_RST;
      hue        = '{4'd0, 4'd11, 4'd12, 4'd15, 4'd1, 4'd2, 4'd9, 4'd4,
                     4'd8, 4'd10, 4'd7, 4'd6, 4'd14, 4'd3, 4'd5, 4'd13};
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
      case (idx)
        CFG_X_LEFT: x_left = val;
        CFG_Y_TOP:  y_top  = val;
        CFG_X_STEP: x_step = val;
        CFG_Y_STEP: y_step = val;
        default: ;
      endcase
    endfunction

    // 16-bit abs below 2.0; most negative value wraps and stays in
    function bit inside_box(logic signed [COORD_W-1:0] v);
      return (v > -ESCAPE && v < ESCAPE) || (v == MOST_NEG);
    endfunction

    function out_item_t escape_time(in_item_t px);
      logic signed [COORD_W-1:0] c_re, c_im, re, im;
      logic signed [31:0]        re_w, im_w, rr, ii, ri;
      int                        n;
      out_item_t                 r;
      c_re = x_left + (COORD_W'(px.col) + 16'd1) * x_step;
      c_im = y_top + (COORD_W'(px.row) - 16'd2) * y_step;
      re   = '0;
      im   = '0;
      n    = 0;
      while (n < MAX_ITER && inside_box(re) && inside_box(im)) begin
        re_w = re;
        im_w = im;
        rr   = (re_w * re_w) >>> FRAC_BITS;
        ii   = (im_w * im_w) >>> FRAC_BITS;
        ri   = (re_w * im_w) >>> (FRAC_BITS - 1);
        re   = COORD_W'(rr - ii + c_re);
        im   = COORD_W'(ri + c_im);
        n++;
      end
      r.pixel_col  = px.col;
      r.pixel_row  = px.row;
      r.iterations = CNT_W'(n);
      r.color      = (n == MAX_ITER) ? '0 : hue[n % 16];
      return r;
    endfunction

    function void note_pixel(in_item_t px);
      expected_px.push_back(escape_time(px));
    endfunction

    function void check_pixel(out_item_t got);
      out_item_t exp_px;
      if (expected_px.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: col=%0d row=%0d iter=%0d color=%0d",
                   got.pixel_col, got.pixel_row, got.iterations, got.color);
        return;
      end
      exp_px = expected_px.pop_front();
      if (got.pixel_col !== exp_px.pixel_col || got.pixel_row !== exp_px.pixel_row ||
          got.iterations !== exp_px.iterations || got.color !== exp_px.color) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp %0d,%0d iter=%0d color=%0d / got %0d,%0d iter=%0d color=%0d",
                   exp_px.pixel_col, exp_px.pixel_row, exp_px.iterations, exp_px.color,
                   got.pixel_col, got.pixel_row, got.iterations, got.color);
      end
    endfunction

    function int pending();
      return expected_px.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = CFG_X_LEFT;
  logic [COORD_W-1:0]   cfg_wdata = '0;

  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   stall_pct = 0;
  int   idle_pct  = 0;

  pixel_scoreboard board;

  mandelbrot_pixel_iterator_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) board.note_pixel(in_data);
    if (rst_n && out_valid && out_ready) board.check_pixel(out_data);
  end

  // result side: random stalls, plus one long hold-off to back up the pipe
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send_pixel(input logic [POS_W-1:0] px_col, input logic [POS_W-1:0] px_row);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{col: px_col, row: px_row};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_pixels();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_view(input logic [COORD_W-1:0] xl, input logic [COORD_W-1:0] yt,
                            input logic [COORD_W-1:0] xs, input logic [COORD_W-1:0] ys);
    logic [COORD_W-1:0]   vals [4];
    logic [CFG_IDX_W-1:0] regs [4];
    vals = '{xl, yt, xs, ys};
    regs = '{CFG_X_LEFT, CFG_Y_TOP, CFG_X_STEP, CFG_Y_STEP};
    drain_pixels();
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      board.set_reg(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [COORD_W-1:0] xl, yt, xs, ys;
    int                 mode;
    board = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // default view: screen corners, rows above the top, off-screen positions
    send_pixel(8'd0, 8'd0);     send_pixel(8'd159, 8'd191);
    send_pixel(8'd0, 8'd1);     send_pixel(8'd1, 8'd2);
    send_pixel(8'd80, 8'd96);   send_pixel(8'd159, 8'd0);
    send_pixel(8'd0, 8'd191);   send_pixel(8'd255, 8'd255);
    send_pixel(8'd128, 8'd64);  send_pixel(8'd127, 8'd127);
    send_pixel(8'd40, 8'd100);  send_pixel(8'd120, 8'd20);

    // real part pinned at the most negative value
    write_view(16'h8000, 16'h0000, 16'h0000, 16'h0000);
    send_pixel(8'd0, 8'd0);     send_pixel(8'd159, 8'd191);
    // imaginary part pinned at the most negative value
    write_view(16'h0000, 16'h8000, 16'h0000, 16'h0000);
    send_pixel(8'd0, 8'd0);     send_pixel(8'd200, 8'd3);
    // register extremes
    write_view(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    send_pixel(8'd0, 8'd0);     send_pixel(8'd159, 8'd191);
    send_pixel(8'd255, 8'd255); send_pixel(8'd0, 8'd1);
    write_view(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    send_pixel(8'd0, 8'd0);     send_pixel(8'd255, 8'd1);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: write_view(16'hF800, 16'hF800, 16'd25, 16'd21);
        1: write_view(16'hFA00, 16'hFC00, 16'd4, 16'd5);
        2: write_view(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        3: write_view(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        default: begin
          if (p % 2 == 0) begin
            xl = 16'hF600 + COORD_W'($urandom_range(0, 3072));
            yt = 16'hF800 + COORD_W'($urandom_range(0, 4096));
            xs = COORD_W'($urandom_range(0, 64) - 32);
            ys = COORD_W'($urandom_range(0, 64) - 32);
          end else begin
            xl = COORD_W'($urandom);
            yt = COORD_W'($urandom);
            xs = COORD_W'($urandom);
            ys = COORD_W'($urandom);
          end
          write_view(xl, yt, xs, ys);
        end
      endcase
      mode = p % 4;
      idle_pct = (mode == 1) ? 76 : (mode == 3) ? 6 : 0;
      stall_pct <= (mode == 2) ? 76 : (mode == 3) ? 6 : 0;
      if (p == 0) hold_req <= 1'b1;
      for (int k = 0; k < RANDOM_PIXELS; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_pixel(POS_W'($urandom_range(0, 255)), POS_W'($urandom_range(0, 255)));
        else
          send_pixel(POS_W'($urandom_range(0, 159)), POS_W'($urandom_range(0, 191)));
      end
    end

    drain_pixels();
    repeat (40) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
